### rtl/byte_stream_fast_hash_defines.svh
// Assertion macros used by the hash block's back end (bsfh_back).
// Define NO_ASSERTIONS to compile every check away.
`ifndef BYTE_STREAM_FAST_HASH_DEFINES_SVH
`define BYTE_STREAM_FAST_HASH_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Clocked check, masked while reset is held
`define BSFH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked check that also holds during reset
`define BSFH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BSFH_ASSERT(lbl, prop, msg)
`define BSFH_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### rtl/bsfh_pkg.sv
// Types, constants and round functions of the byte stream hash.
// Used by the front, queue, back and top-level modules; no dependencies.
package bsfh_pkg;

  localparam int WORD_W     = 32;
  localparam int COUNT_W    = 3;
  localparam int LEN_W      = 31;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 32;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  // What the back end does with one word
  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_TAIL1 = 3'd1,
    KIND_TAIL2 = 3'd2,
    KIND_TAIL3 = 3'd3,
    KIND_FULL  = 3'd4
  } bsfh_kind_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    bsfh_kind_t        kind;
    logic              first;
    logic              last;
    logic [LEN_W-1:0]  seed;
  } bsfh_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } bsfh_fifo_stat_t;

  function automatic logic [WORD_W-1:0] sext8(input logic [7:0] b);
    return {{(WORD_W-8){b[7]}}, b};
  endfunction

  function automatic logic [WORD_W-1:0] full_round(input logic [WORD_W-1:0] h_in,
                                                   input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] h;
    logic [WORD_W-1:0] t;
    h = h_in + {16'd0, w[15:0]};
    t = ({16'd0, w[31:16]} << 11) ^ h;
    h = (h << 16) ^ t;
    h = h + (h >> 11);
    return h;
  endfunction

  function automatic logic [WORD_W-1:0] tail_round(input logic [WORD_W-1:0] h_in,
                                                   input logic [WORD_W-1:0] w,
                                                   input bsfh_kind_t        kind);
    logic [WORD_W-1:0] h;
    h = h_in;
    unique case (kind)
      KIND_TAIL3: begin
        h = h + {16'd0, w[15:0]};
        h = h ^ (h << 16);
        h = h ^ (sext8(w[23:16]) << 18);
        h = h + (h >> 11);
      end
      KIND_TAIL2: begin
        h = h + {16'd0, w[15:0]};
        h = h ^ (h << 11);
        h = h + (h >> 17);
      end
      KIND_TAIL1: begin
        h = h + sext8(w[7:0]);
        h = h ^ (h << 10);
        h = h + (h >> 1);
      end
      KIND_NONE, KIND_FULL: h = h_in;
      default:              h = h_in;
    endcase
    return h;
  endfunction

  // First three avalanche steps
  function automatic logic [WORD_W-1:0] aval_lo(input logic [WORD_W-1:0] h_in);
    logic [WORD_W-1:0] h;
    h = h_in ^ (h_in << 3);
    h = h + (h >> 5);
    h = h ^ (h << 4);
    return h;
  endfunction

  // Last three avalanche steps
  function automatic logic [WORD_W-1:0] aval_hi(input logic [WORD_W-1:0] h_in);
    logic [WORD_W-1:0] h;
    h = h_in + (h_in >> 17);
    h = h ^ (h << 25);
    h = h + (h >> 6);
    return h;
  endfunction

endpackage

### rtl/bsfh_front.sv
// Front end: input register stage that classifies each request by byte count.
// Depends on bsfh_pkg; pushes classified items into bsfh_fifo.
module bsfh_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [bsfh_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                              in_tuser,
  input  logic                              in_tlast,
  input  bsfh_pkg::bsfh_fifo_stat_t         fifo_stat,
  output logic                              push,
  output bsfh_pkg::bsfh_item_t              push_item
);

  logic                 item_valid_r;
  logic                 item_valid_nxt;
  bsfh_pkg::bsfh_item_t item_r;
  bsfh_pkg::bsfh_item_t item_nxt;
  bsfh_pkg::bsfh_kind_t kind;
  logic [bsfh_pkg::COUNT_W-1:0] count;

  assign count = in_tdata[34:32];

  // Counts above four saturate to a full word
  always_comb begin
    unique case (count)
      3'd0:    kind = bsfh_pkg::KIND_NONE;
      3'd1:    kind = bsfh_pkg::KIND_TAIL1;
      3'd2:    kind = bsfh_pkg::KIND_TAIL2;
      3'd3:    kind = bsfh_pkg::KIND_TAIL3;
      default: kind = bsfh_pkg::KIND_FULL;
    endcase
  end

  assign push      = item_valid_r && !fifo_stat.full;
  assign in_tready = !item_valid_r || push;
  assign push_item = item_r;

  always_comb begin
    item_valid_nxt = item_valid_r;
    item_nxt       = item_r;
    if (push) begin
      item_valid_nxt = 1'b0;
    end
    if (in_tvalid && in_tready) begin
      item_valid_nxt = 1'b1;
      item_nxt.word  = in_tdata[31:0];
      item_nxt.kind  = kind;
      item_nxt.first = in_tuser;
      item_nxt.last  = in_tlast;
      item_nxt.seed  = in_tdata[65:35];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
    end
    item_r <= item_nxt;
  end

endmodule

### rtl/bsfh_fifo.sv
// Short queue between the front and back ends of the hash block.
// Depends on bsfh_pkg for the item type and depth.
module bsfh_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  bsfh_pkg::bsfh_item_t      push_item,
  input  logic                      pop,
  output bsfh_pkg::bsfh_item_t      pop_item,
  output bsfh_pkg::bsfh_fifo_stat_t stat
);

  bsfh_pkg::bsfh_item_t             slot_r [bsfh_pkg::FIFO_DEPTH];
  logic [bsfh_pkg::FIFO_AW-1:0]     wr_ptr_r;
  logic [bsfh_pkg::FIFO_AW-1:0]     wr_ptr_nxt;
  logic [bsfh_pkg::FIFO_AW-1:0]     rd_ptr_r;
  logic [bsfh_pkg::FIFO_AW-1:0]     rd_ptr_nxt;
  logic [bsfh_pkg::FIFO_CW-1:0]     count_r;
  logic [bsfh_pkg::FIFO_CW-1:0]     count_nxt;

  assign stat.full  = (count_r == bsfh_pkg::FIFO_CW'(bsfh_pkg::FIFO_DEPTH));
  assign stat.empty = (count_r == '0);
  assign pop_item   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### rtl/bsfh_back.sv
// Back end: word rounds on the running hash, then a two-stage avalanche and
// the output register. Depends on bsfh_pkg and the assertion macro header.
`include "byte_stream_fast_hash_defines.svh"
module bsfh_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bsfh_pkg::bsfh_fifo_stat_t         fifo_stat,
  input  bsfh_pkg::bsfh_item_t              item,
  output logic                              pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [bsfh_pkg::OUT_DATA_W-1:0]   out_tdata
);

  logic [bsfh_pkg::WORD_W-1:0] running_hash_r;
  logic [bsfh_pkg::WORD_W-1:0] running_hash_nxt;
  logic                        a_valid_r;
  logic [bsfh_pkg::WORD_W-1:0] a_hash_r;
  logic                        b_valid_r;
  logic [bsfh_pkg::WORD_W-1:0] b_hash_r;
  logic                        out_valid_r;
  logic [bsfh_pkg::WORD_W-1:0] out_hash_r;
  logic [bsfh_pkg::WORD_W-1:0] h_in;
  logic [bsfh_pkg::WORD_W-1:0] h_out;
  logic                        out_load;
  logic                        b_free;
  logic                        b_load;
  logic                        a_free;

  assign out_load = b_valid_r && (!out_valid_r || out_tready);
  assign b_free   = !b_valid_r || out_load;
  assign b_load   = a_valid_r && b_free;
  assign a_free   = !a_valid_r || b_load;
  // Only a final word needs room in the avalanche stages
  assign pop      = !fifo_stat.empty && (!item.last || a_free);

  assign h_in  = item.first ? {1'b0, item.seed} : running_hash_r;
  assign h_out = (item.kind == bsfh_pkg::KIND_FULL) ? bsfh_pkg::full_round(h_in, item.word)
                                                     : bsfh_pkg::tail_round(h_in, item.word,
                                                                            item.kind);

  // Clear the running hash once a message is finished
  always_comb begin
    running_hash_nxt = running_hash_r;
    if (pop) begin
      running_hash_nxt = item.last ? '0 : h_out;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_hash_r <= '0;
      a_valid_r      <= 1'b0;
      b_valid_r      <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      running_hash_r <= running_hash_nxt;
      if (pop && item.last) begin
        a_valid_r <= 1'b1;
      end else if (b_load) begin
        a_valid_r <= 1'b0;
      end
      if (b_load) begin
        b_valid_r <= 1'b1;
      end else if (out_load) begin
        b_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (pop && item.last) begin
      a_hash_r <= h_out;
    end
    if (b_load) begin
      b_hash_r <= bsfh_pkg::aval_lo(a_hash_r);
    end
    if (out_load) begin
      out_hash_r <= bsfh_pkg::aval_hi(b_hash_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_hash_r;

  `BSFH_ASSERT(a_clear_after_last, (pop && item.last) |=> (running_hash_r == '0), "running hash not cleared after final word")
  `BSFH_ASSERT(a_stage_a_hold, (a_valid_r && !b_free) |=> (a_valid_r && $stable(a_hash_r)), "avalanche input lost while stalled")
  `BSFH_ASSERT(a_stage_b_hold, (b_valid_r && !out_load) |=> (b_valid_r && $stable(b_hash_r)), "avalanche middle stage lost while stalled")
  `BSFH_ASSERT(a_no_overrun, !(pop && item.last && a_valid_r && !b_load), "final word popped into occupied stage")

endmodule

### rtl/byte_stream_fast_hash.sv
// 32-bit SuperFastHash over a byte stream of little-endian words.
// Input channel: one request per word; in_tuser marks the first word of a message
//   (seeds the hash with total_length), in_tlast marks the final word.
// Every word but the last carries four bytes; the last may carry zero to four.
// Output channel: one request holding the finished hash per message.
// Throughput: one word per cycle unless the queue or the avalanche stages stall;
//   the word round on the running hash register in the back end is combinational.
// Path to the output: a final word passes the input stage, the queue, the round
//   and two avalanche stages before its hash is shown on out_tvalid.
// Reset clears the running hash to zero and empties every stage.
// When the receiver stalls, the output and avalanche stages hold, the queue
//   of four words fills, and then in_tready drops; words keep flowing
//   between messages while a result waits.
// Depends on bsfh_pkg, bsfh_front, bsfh_fifo and bsfh_back.
module byte_stream_fast_hash (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // word [31:0], byte_count [34:32], total_length [65:35], zero [71:66]
  input  logic [bsfh_pkg::IN_DATA_W-1:0]  in_tdata,
  // first [0]
  input  logic                            in_tuser,
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // hash_value [31:0]
  output logic [bsfh_pkg::OUT_DATA_W-1:0] out_tdata
);

  bsfh_pkg::bsfh_fifo_stat_t fifo_stat;
  bsfh_pkg::bsfh_item_t      push_item;
  bsfh_pkg::bsfh_item_t      pop_item;
  logic                      push;
  logic                      pop;

  bsfh_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .fifo_stat (fifo_stat),
    .push      (push),
    .push_item (push_item)
  );

  bsfh_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .stat      (fifo_stat)
  );

  bsfh_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_stat  (fifo_stat),
    .item       (pop_item),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### test/tb_byte_stream_fast_hash.sv
// Testbench for byte_stream_fast_hash: streams directed and random messages,
// predicts each finished hash in step with accepted words and checks the results.
// Depends on bsfh_pkg and the byte_stream_fast_hash RTL.
`timescale 1ns / 1ps

module tb_byte_stream_fast_hash;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_WORDS = 1250;

  typedef struct {
    logic [bsfh_pkg::WORD_W-1:0]  word;
    logic [bsfh_pkg::COUNT_W-1:0] count;
    logic                         first;
    logic                         last;
    logic [bsfh_pkg::LEN_W-1:0]   length;
  } hash_req_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_CHOPPY,
    RX_HOLD
  } rx_mode_t;

  logic                            clk;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [bsfh_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic                            in_tuser   = 1'b0;
  logic                            in_tlast   = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [bsfh_pkg::OUT_DATA_W-1:0] out_tdata;

  hash_req_t                   pending_reqs[$];
  logic [bsfh_pkg::WORD_W-1:0] hash_expected[$];
  hash_req_t                   offered_req;
  logic [bsfh_pkg::WORD_W-1:0] hash_acc;
  int                          err_count;
  int                          idle_cycles;
  int                          burst_left;
  int                          gap_left;
  rx_mode_t                    rx_mode;
  int                          rx_left;
  int                          rx_phase;

  byte_stream_fast_hash u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (err_count < 40)
      $display("%0t ns: %s", $time, msg);
    err_count++;
  endtask

  function automatic void queue_req(input logic [bsfh_pkg::WORD_W-1:0] word, input int count,
                                    input bit first, input bit last, input int length);
    hash_req_t r;
    r.word   = word;
    r.count  = count[bsfh_pkg::COUNT_W-1:0];
    r.first  = first;
    r.last   = last;
    r.length = length[bsfh_pkg::LEN_W-1:0];
    pending_reqs.push_back(r);
  endfunction

  // Fold one accepted word into the running hash; finish and queue on last
  task automatic absorb_req(input hash_req_t r);
    logic [bsfh_pkg::WORD_W-1:0] h;
    logic [bsfh_pkg::WORD_W-1:0] t;
    bsfh_pkg::bsfh_kind_t        kind;
    h    = r.first ? {1'b0, r.length} : hash_acc;
    kind = (r.count >= 3'd4) ? bsfh_pkg::KIND_FULL : bsfh_pkg::bsfh_kind_t'(r.count);
    case (kind)
      bsfh_pkg::KIND_FULL: begin
        h = h + {16'd0, r.word[15:0]};
        t = ({16'd0, r.word[31:16]} << 11) ^ h;
        h = (h << 16) ^ t;
        h = h + (h >> 11);
      end
      bsfh_pkg::KIND_TAIL3: begin
        h = h + {16'd0, r.word[15:0]};
        h = h ^ (h << 16);
        h = h ^ ({{24{r.word[23]}}, r.word[23:16]} << 18);
        h = h + (h >> 11);
      end
      bsfh_pkg::KIND_TAIL2: begin
        h = h + {16'd0, r.word[15:0]};
        h = h ^ (h << 11);
        h = h + (h >> 17);
      end
      bsfh_pkg::KIND_TAIL1: begin
        h = h + {{24{r.word[7]}}, r.word[7:0]};
        h = h ^ (h << 10);
        h = h + (h >> 1);
      end
      default: ;
    endcase
    if (r.last) begin
      h = h ^ (h << 3);
      h = h + (h >> 5);
      h = h ^ (h << 4);
      h = h + (h >> 17);
      h = h ^ (h << 25);
      h = h + (h >> 6);
      hash_expected.push_back(h);
      hash_acc = '0;
    end else begin
      hash_acc = h;
    end
  endtask

  // Driver: bursts of requests separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      hash_acc   = '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_tvalid && in_tready)
        absorb_req(offered_req);
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          offered_req = pending_reqs.pop_front();
          in_tdata  <= {{(bsfh_pkg::IN_DATA_W-66){1'b0}}, offered_req.length,
                        offered_req.count, offered_req.word};
          in_tuser  <= offered_req.first;
          in_tlast  <= offered_req.last;
          in_tvalid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: phases of free flow, random stalls and long hold-offs
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_mode  = RX_FREE;
      rx_left  = 0;
      rx_phase = 0;
    end else begin
      if (rx_left == 0) begin
        rx_phase++;
        // hold off long enough to fill the queue and stall the input
        if (rx_phase == 4 || $urandom_range(0, 9) == 0) begin
          rx_mode = RX_HOLD;
          rx_left = $urandom_range(40, 100);
        end else begin
          rx_mode = ($urandom_range(0, 1) == 0) ? RX_FREE : RX_CHOPPY;
          rx_left = $urandom_range(20, 80);
        end
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_HOLD:   out_tready <= 1'b0;
        RX_CHOPPY: out_tready <= ($urandom_range(0, 2) != 0);
        default:   out_tready <= 1'b1;
      endcase
    end
  end

  // Monitor: compare each accepted hash with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (hash_expected.size() == 0) begin
        report_mismatch($sformatf("hash %08h with no message pending", out_tdata));
      end else begin
        if (out_tdata !== hash_expected[0])
          report_mismatch($sformatf("hash_value mismatch: got %08h, expected %08h",
                                    out_tdata, hash_expected[0]));
        void'(hash_expected.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_byte_stream_fast_hash: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int n_words;
    int tail;
    int k;
    err_count = 0;

    // zero length, single bytes either side of the sign bit, two and three bytes
    queue_req(32'h0000_0000, 0, 1, 1, 0);
    queue_req(32'hFFFF_FF7F, 1, 1, 1, 1);
    queue_req(32'h0000_0080, 1, 1, 1, 1);
    queue_req(32'h0000_FFFF, 2, 1, 1, 2);
    queue_req(32'h00FF_FFFF, 3, 1, 1, 3);
    queue_req(32'hAA7F_1234, 3, 1, 1, 3);
    // full words, widest length, length not matching the words
    queue_req(32'hFFFF_FFFF, 4, 1, 0, 32'h7FFF_FFFF);
    queue_req(32'h0000_0000, 4, 0, 1, 0);
    // counts above four saturate
    queue_req(32'h1357_9BDF, 5, 1, 0, 12);
    queue_req(32'h2468_ACE0, 6, 0, 0, 0);
    queue_req(32'h8001_FF80, 7, 0, 1, 0);
    // empty word and short word in the middle of a message
    queue_req(32'hDEAD_BEEF, 4, 1, 0, 11);
    queue_req(32'hFFFF_FFFF, 0, 0, 0, 0);
    queue_req(32'h55AA_C3C3, 2, 0, 0, 0);
    queue_req(32'h0123_4581, 1, 0, 1, 32'h7FFF_FFFF);
    // no first after a finished message: continue from zero
    queue_req(32'hCAFE_F00D, 4, 0, 0, 32'h2AAA_AAAA);
    queue_req(32'h0080_8080, 3, 0, 1, 0);
    // last word empty after full words
    queue_req(32'h0BAD_C0DE, 4, 1, 0, 4);
    queue_req(32'h7777_7777, 0, 0, 1, 4);
    // reseed part way through a message
    queue_req(32'h1111_2222, 4, 1, 0, 8);
    queue_req(32'h3333_4444, 4, 1, 0, 100);
    queue_req(32'h5555_6666, 4, 0, 1, 0);

    k = 0;
    while (k < RANDOM_WORDS) begin
      if ($urandom_range(0, 99) < 85) begin
        n_words = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        tail    = $urandom_range(0, 4);
        for (int i = 0; i < n_words; i++)
          queue_req($urandom(), (i == n_words - 1) ? tail : 4, i == 0, i == n_words - 1,
                    4 * (n_words - 1) + tail);
        k += n_words;
      end else begin
        // broken sequence: any count, flags and length
        n_words = $urandom_range(1, 6);
        for (int i = 0; i < n_words; i++)
          queue_req($urandom(), $urandom_range(0, 7), $urandom_range(0, 1),
                    $urandom_range(0, 9) < 3, $urandom() & 32'h7FFF_FFFF);
        k += n_words;
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_tvalid || hash_expected.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    if (err_count == 0 && hash_expected.size() == 0) begin
      $display("tb_byte_stream_fast_hash: PASS");
    end else begin
      $display("tb_byte_stream_fast_hash: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/bsfh_pkg.sv
rtl/bsfh_front.sv
rtl/bsfh_fifo.sv
rtl/bsfh_back.sv
rtl/byte_stream_fast_hash.sv
test/tb_byte_stream_fast_hash.sv
